>>> rtl/gess_pkg.sv
package gess_pkg;

  localparam int NV  = 256;
  localparam int NE  = 1024;
  localparam int VW  = 9;
  localparam int EW  = 11;
  localparam int VAW = $clog2(NV);
  localparam int EAW = $clog2(NE);
  localparam int DGW = 12;

  localparam logic [3:0] CMD_ADD_VERTEX = 4'd0;
  localparam logic [3:0] CMD_ADD_EDGE   = 4'd1;
  localparam logic [3:0] CMD_FIND_DIR   = 4'd2;
  localparam logic [3:0] CMD_FIND_ANY   = 4'd3;
  localparam logic [3:0] CMD_RM_EDGE    = 4'd4;
  localparam logic [3:0] CMD_RM_VERTEX  = 4'd5;
  localparam logic [3:0] CMD_DEGREE     = 4'd6;
  localparam logic [3:0] CMD_NEXT_EDGE  = 4'd7;
  localparam logic [3:0] CMD_ENDPOINTS  = 4'd8;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [1:0] SEL_BOTH = 2'd0;
  localparam logic [1:0] SEL_OUT  = 2'd1;
  localparam logic [1:0] SEL_IN   = 2'd2;
  localparam logic [1:0] SEL_BAD  = 2'd3;

  localparam logic CFG_VERTEX_LIMIT = 1'b0;

  function automatic logic [VAW-1:0] vidx(input logic [VW-1:0] v);
    logic [VW-1:0] t;
    t = v - VW'(1);
    return t[VAW-1:0];
  endfunction

  function automatic logic [EAW-1:0] eidx(input logic [EW-1:0] e);
    logic [EW-1:0] t;
    t = e - EW'(1);
    return t[EAW-1:0];
  endfunction

endpackage

>>> rtl/gess_ram.sv
module gess_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/graph_edge_star_store.sv
// Channel  Handshake             Payload
// in       in_valid / in_ready   command, vertex_a, vertex_b, edge_id, star_select
// out      out_valid / out_ready status, result_vertex, result_edge, other_vertex,
//                                degree, live_vertices, live_edges
// cfg      cfg_write             cfg_index, cfg_data
// One item is worked on at a time; memory reads are registered and need a wait state.
// Add vertex reads no memory; list walks read the links of each visited edge in turn.
// Add edge also scans for a free slot from the lowest-free hint, one slot at a time.
// Removing a vertex unlinks each incident edge from the opposite list.
// After reset a pass clears every edge endpoint entry before items are taken.
// A result waiting on out_ready holds the block in its final step.
module graph_edge_star_store import gess_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [3:0]     command,
  input  logic [VW-1:0]  vertex_a,
  input  logic [VW-1:0]  vertex_b,
  input  logic [EW-1:0]  edge_id,
  input  logic [1:0]     star_select,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     status,
  output logic [VW-1:0]  result_vertex,
  output logic [EW-1:0]  result_edge,
  output logic [VW-1:0]  other_vertex,
  output logic [DGW-1:0] degree,
  output logic [VW-1:0]  live_vertices,
  output logic [EW-1:0]  live_edges,
  input  logic           cfg_write,
  input  logic           cfg_index,
  input  logic [EW-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_EXEC,
    S_FHEAD, S_FHEADW, S_FNODE, S_FNODEW, S_FRET,
    S_SLOT, S_SLOTW, S_LINK, S_LINKW,
    S_EREAD, S_EREADW, S_EUNL2, S_EFREE,
    S_UHEAD, S_UHEADW, S_UNODE, S_UNODEW,
    S_VHEAD, S_VHEADW, S_VNODE, S_VNODEW, S_VFREE, S_VDONE,
    S_WHEAD, S_WHEADW, S_WNODE, S_WNODEW,
    S_DONE
  } state_t;

  state_t state, uret;

  logic [VW-1:0]  vertex_limit, vlim, vc, vlive;
  logic [EW-1:0]  edge_limit, elim, elive, hint;
  logic [NV-1:0]  present;
  logic [EAW-1:0] clr;

  logic [3:0]     cmd;
  logic [VW-1:0]  a, b, fx, fy, uv, etgt;
  logic [EW-1:0]  eid, cur, wnext, uid, ucur, uprev;
  logic [1:0]     sel;
  logic           fswap, fhit, ukind, vph, wph;

  logic [2:0]     r_st;
  logic [VW-1:0]  r_rv, r_ov;
  logic [EW-1:0]  r_re;
  logic [DGW-1:0] r_deg;

  logic           oh_we, ih_we, en_we, no_we, ni_we;
  logic [VAW-1:0] oh_waddr, ih_waddr, oh_raddr, ih_raddr;
  logic [EAW-1:0] en_waddr, no_waddr, ni_waddr, en_raddr, no_raddr, ni_raddr;
  logic [EW-1:0]  oh_wdata, ih_wdata, no_wdata, ni_wdata, oh_rd, ih_rd, no_rd, ni_rd;
  logic [2*VW-1:0] en_wdata, en_rd;
  logic [VW-1:0]  en_org, en_tgt;

  assign vlim = (vertex_limit > VW'(NV)) ? VW'(NV) : vertex_limit;
  assign elim = (edge_limit > EW'(NE)) ? EW'(NE) : edge_limit;
  assign en_org = en_rd[2*VW-1:VW];
  assign en_tgt = en_rd[VW-1:0];
  assign in_ready = (state == S_IDLE);

  function automatic logic vok(input logic [VW-1:0] v, input logic [NV-1:0] pr);
    return (v != '0) && (v <= VW'(NV)) && pr[vidx(v)];
  endfunction

  function automatic logic eok(input logic [EW-1:0] e);
    return (e != '0) && (e <= EW'(NE));
  endfunction

  gess_ram #(.WIDTH(EW), .DEPTH(NV)) u_ohead (
    .clk(clk), .we(oh_we), .waddr(oh_waddr), .wdata(oh_wdata), .raddr(oh_raddr), .rdata(oh_rd)
  );
  gess_ram #(.WIDTH(EW), .DEPTH(NV)) u_ihead (
    .clk(clk), .we(ih_we), .waddr(ih_waddr), .wdata(ih_wdata), .raddr(ih_raddr), .rdata(ih_rd)
  );
  gess_ram #(.WIDTH(2*VW), .DEPTH(NE)) u_ends (
    .clk(clk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata), .raddr(en_raddr), .rdata(en_rd)
  );
  gess_ram #(.WIDTH(EW), .DEPTH(NE)) u_nxout (
    .clk(clk), .we(no_we), .waddr(no_waddr), .wdata(no_wdata), .raddr(no_raddr), .rdata(no_rd)
  );
  gess_ram #(.WIDTH(EW), .DEPTH(NE)) u_nxin (
    .clk(clk), .we(ni_we), .waddr(ni_waddr), .wdata(ni_wdata), .raddr(ni_raddr), .rdata(ni_rd)
  );

  always_comb begin
    oh_we = 1'b0; oh_waddr = vidx(a); oh_wdata = '0;
    ih_we = 1'b0; ih_waddr = vidx(a); ih_wdata = '0;
    en_we = 1'b0; en_waddr = eidx(cur); en_wdata = '0;
    no_we = 1'b0; no_waddr = eidx(cur); no_wdata = '0;
    ni_we = 1'b0; ni_waddr = eidx(cur); ni_wdata = '0;
    oh_raddr = (state == S_FHEAD) ? vidx(fx) : (state == S_UHEAD) ? vidx(uv) : vidx(a);
    ih_raddr = (state == S_LINK) ? vidx(b) : (state == S_UHEAD) ? vidx(uv) : vidx(a);
    en_raddr = (state == S_EREAD) ? eidx(eid) : eidx(cur);
    no_raddr = (state == S_UNODE) ? eidx(ucur) : eidx(cur);
    ni_raddr = (state == S_UNODE) ? eidx(ucur) : eidx(cur);
    case (state)
      S_CLEAR: begin
        en_we = 1'b1;
        en_waddr = clr;
      end
      S_EXEC: begin
        if (cmd == CMD_ADD_VERTEX && vc < vlim) begin
          oh_we = 1'b1; oh_waddr = vc[VAW-1:0];
          ih_we = 1'b1; ih_waddr = vc[VAW-1:0];
        end
      end
      S_LINKW: begin
        en_we = 1'b1; en_wdata = {a, b};
        no_we = 1'b1; no_wdata = oh_rd;
        ni_we = 1'b1; ni_wdata = ih_rd;
        oh_we = 1'b1; oh_waddr = vidx(a); oh_wdata = cur;
        ih_we = 1'b1; ih_waddr = vidx(b); ih_wdata = cur;
      end
      S_UNODEW: begin
        if (ucur == uid) begin
          if (!ukind) begin
            if (uprev == '0) begin
              oh_we = 1'b1; oh_waddr = vidx(uv); oh_wdata = no_rd;
            end else begin
              no_we = 1'b1; no_waddr = eidx(uprev); no_wdata = no_rd;
            end
          end else begin
            if (uprev == '0) begin
              ih_we = 1'b1; ih_waddr = vidx(uv); ih_wdata = ni_rd;
            end else begin
              ni_we = 1'b1; ni_waddr = eidx(uprev); ni_wdata = ni_rd;
            end
          end
        end
      end
      S_EFREE, S_VFREE: begin
        en_we = 1'b1;
        en_waddr = eidx(uid);
      end
      S_VDONE: begin
        oh_we = 1'b1;
        ih_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
      vertex_limit <= VW'(NV);
      edge_limit <= EW'(NE);
      vc <= '0;
      vlive <= '0;
      elive <= '0;
      present <= '0;
      hint <= EW'(1);
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_VERTEX_LIMIT) begin
          vertex_limit <= cfg_data[VW-1:0];
        end else begin
          edge_limit <= cfg_data;
        end
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + EAW'(1);
          if (clr == EAW'(NE - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd <= command; a <= vertex_a; b <= vertex_b; eid <= edge_id; sel <= star_select;
            r_st <= ST_INVALID; r_rv <= '0; r_re <= '0; r_ov <= '0; r_deg <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          case (cmd) inside
            CMD_ADD_VERTEX: begin
              if (vc >= vlim) begin
                r_st <= ST_FULL;
              end else begin
                vc <= vc + VW'(1);
                present[vc[VAW-1:0]] <= 1'b1;
                vlive <= vlive + VW'(1);
                r_rv <= vc + VW'(1);
                r_st <= ST_OK;
              end
            end
            CMD_ADD_EDGE: begin
              if (elive >= elim) begin
                r_st <= ST_FULL;
              end else if (vok(a, present) && vok(b, present)) begin
                fx <= a; fy <= b; fswap <= 1'b0;
                state <= S_FHEAD;
              end
            end
            CMD_FIND_DIR, CMD_FIND_ANY: begin
              if (vok(a, present) && vok(b, present)) begin
                fx <= a; fy <= b; fswap <= 1'b0;
                state <= S_FHEAD;
              end
            end
            CMD_RM_EDGE, CMD_ENDPOINTS: begin
              if (eok(eid)) state <= S_EREAD;
            end
            CMD_RM_VERTEX: begin
              if (vok(a, present)) begin
                vph <= 1'b0;
                state <= S_VHEAD;
              end
            end
            CMD_DEGREE, CMD_NEXT_EDGE: begin
              if (vok(a, present) && !(cmd == CMD_NEXT_EDGE && sel == SEL_BAD)) begin
                wph <= (cmd == CMD_NEXT_EDGE && sel == SEL_IN);
                state <= S_WHEAD;
              end
            end
            default: ;
          endcase
        end
        S_FHEAD: state <= S_FHEADW;
        S_FHEADW: begin
          cur <= oh_rd;
          state <= S_FNODE;
        end
        S_FNODE: begin
          if (cur == '0) begin
            fhit <= 1'b0;
            state <= S_FRET;
          end else begin
            state <= S_FNODEW;
          end
        end
        S_FNODEW: begin
          if (en_tgt == fy) begin
            fhit <= 1'b1;
            state <= S_FRET;
          end else begin
            cur <= no_rd;
            state <= S_FNODE;
          end
        end
        S_FRET: begin
          if (cmd == CMD_ADD_EDGE) begin
            if (fhit) begin
              r_st <= ST_DUP;
              state <= S_DONE;
            end else begin
              cur <= hint;
              state <= S_SLOT;
            end
          end else if (!fhit && cmd == CMD_FIND_ANY && !fswap) begin
            fx <= b; fy <= a; fswap <= 1'b1;
            state <= S_FHEAD;
          end else begin
            r_st <= fhit ? ST_OK : ST_NOTFOUND;
            r_re <= fhit ? cur : '0;
            state <= S_DONE;
          end
        end
        S_SLOT: begin
          if (cur > EW'(NE)) begin
            r_st <= ST_FULL;
            state <= S_DONE;
          end else begin
            state <= S_SLOTW;
          end
        end
        S_SLOTW: begin
          if (en_org == '0) begin
            state <= S_LINK;
          end else begin
            cur <= cur + EW'(1);
            state <= S_SLOT;
          end
        end
        S_LINK: state <= S_LINKW;
        S_LINKW: begin
          hint <= cur + EW'(1);
          elive <= elive + EW'(1);
          r_re <= cur;
          r_st <= ST_OK;
          state <= S_DONE;
        end
        S_EREAD: state <= S_EREADW;
        S_EREADW: begin
          if (en_org == '0) begin
            r_st <= ST_NOTFOUND;
            state <= S_DONE;
          end else if (cmd == CMD_ENDPOINTS) begin
            r_rv <= en_org; r_ov <= en_tgt; r_re <= eid; r_st <= ST_OK;
            state <= S_DONE;
          end else begin
            ukind <= 1'b0; uv <= en_org; uid <= eid; etgt <= en_tgt; uret <= S_EUNL2;
            state <= S_UHEAD;
          end
        end
        S_EUNL2: begin
          ukind <= 1'b1; uv <= etgt; uret <= S_EFREE;
          state <= S_UHEAD;
        end
        S_EFREE: begin
          if (elive != '0) elive <= elive - EW'(1);
          if (uid < hint) hint <= uid;
          r_st <= ST_OK;
          state <= S_DONE;
        end
        S_UHEAD: state <= S_UHEADW;
        S_UHEADW: begin
          ucur <= ukind ? ih_rd : oh_rd;
          uprev <= '0;
          state <= S_UNODE;
        end
        S_UNODE: state <= (ucur == '0) ? uret : S_UNODEW;
        S_UNODEW: begin
          if (ucur == uid) begin
            state <= uret;
          end else begin
            uprev <= ucur;
            ucur <= ukind ? ni_rd : no_rd;
            state <= S_UNODE;
          end
        end
        S_VHEAD: state <= S_VHEADW;
        S_VHEADW: begin
          cur <= vph ? ih_rd : oh_rd;
          state <= S_VNODE;
        end
        S_VNODE: begin
          if (cur != '0) begin
            state <= S_VNODEW;
          end else if (!vph) begin
            vph <= 1'b1;
            state <= S_VHEAD;
          end else begin
            state <= S_VDONE;
          end
        end
        S_VNODEW: begin
          wnext <= vph ? ni_rd : no_rd;
          ukind <= !vph;
          uv <= vph ? en_org : en_tgt;
          uid <= cur;
          uret <= S_VFREE;
          state <= S_UHEAD;
        end
        S_VFREE: begin
          if (elive != '0) elive <= elive - EW'(1);
          if (uid < hint) hint <= uid;
          cur <= wnext;
          state <= S_VNODE;
        end
        S_VDONE: begin
          present[vidx(a)] <= 1'b0;
          if (vlive != '0) vlive <= vlive - VW'(1);
          r_st <= ST_OK;
          state <= S_DONE;
        end
        S_WHEAD: state <= S_WHEADW;
        S_WHEADW: begin
          cur <= wph ? ih_rd : oh_rd;
          state <= S_WNODE;
        end
        S_WNODE: begin
          if (cur != '0) begin
            r_deg <= r_deg + DGW'(1);
            if (cur > eid && (r_re == '0 || cur < r_re)) r_re <= cur;
            state <= S_WNODEW;
          end else if (!wph && (cmd == CMD_DEGREE || sel == SEL_BOTH)) begin
            wph <= 1'b1;
            state <= S_WHEAD;
          end else begin
            if (cmd == CMD_DEGREE) begin
              r_st <= ST_OK;
              r_re <= '0;
            end else begin
              r_st <= (r_re != '0) ? ST_OK : ST_NOTFOUND;
              r_deg <= '0;
            end
            state <= S_DONE;
          end
        end
        S_WNODEW: begin
          cur <= wph ? ni_rd : no_rd;
          state <= S_WNODE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            status <= r_st;
            result_vertex <= r_rv;
            result_edge <= r_re;
            other_vertex <= r_ov;
            degree <= r_deg;
            live_vertices <= vlive;
            live_edges <= elive;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) elive <= EW'(NE))
    else $error("live edge count above table size");
  assert property (@(posedge clk) disable iff (rst) vlive <= vc)
    else $error("live vertices exceed created vertices");
  assert property (@(posedge clk) disable iff (rst) (hint != '0) && (hint <= EW'(NE + 1)))
    else $error("free slot hint out of range");
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result presented outside the final step");

endmodule
